// ===== src/rebd_pkg.sv =====
// Package for the rotary encoder and push button decoder.
// Holds widths, operation codes, register indexes and reset values; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rebd_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int TURN_W      = 8;
    localparam int CMP_W       = (COUNT_WIDTH > CFG_DATA_W) ? COUNT_WIDTH : CFG_DATA_W;

    typedef enum logic [1:0] {
        MODE_TICK     = 2'd0,
        MODE_RD_BTN   = 2'd1,
        MODE_RD_TURN  = 2'd2,
        MODE_NOP      = 2'd3
    } op_mode_t;

    typedef enum logic [2:0] {
        EV_NONE      = 3'd0,
        EV_CLICK     = 3'd1,
        EV_LONG      = 3'd2,
        EV_HOLD      = 3'd3,
        EV_HOLD_DONE = 3'd4
    } btn_event_t;

    localparam logic [CFG_IDX_W-1:0] REG_ENC_TYPE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LONGPRESS = 2'd2;

    localparam logic [1:0]            ENC_TYPE_RST  = 2'd0;
    localparam logic [CFG_DATA_W-1:0] DEBOUNCE_RST  = 16'd200;
    localparam logic [CFG_DATA_W-1:0] LONGPRESS_RST = 16'd2000;

endpackage : rebd_pkg
`default_nettype wire

// ===== src/rotary_encoder_button_decoder_top.sv =====
// Rotary encoder and push button decoder, top level.
// Quadrature decode, button debounce and event reporting; depends on rebd_pkg.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (s_*): each transfer is a sampling tick carrying the A, B and
//   button pin levels, a read-and-clear of the button event (a hold event stays),
//   a read-and-clear of the rotation count or a no-op. Every transfer yields
//   exactly one result transfer on the m_* channel: the rotation count and
//   button event after a tick, or before the clear for a read.
//   Configuration: cfg_wr_en writes cfg_wr_data into the register at cfg_index
//   (0 encoder type, 1 debounce ticks, 2 long-press ticks) in the same cycle.
//   Each result is registered in the output register; throughput is one item
//   per cycle while the receiver does not stall, as the state updates on every transfer.
//   When the receiver stalls, one further item is taken into a skid stage, and
//   s_ready drops only while that stage is full.
//   Reset (aresetn low, synchronous) clears the count and event, sets the last
//   pin levels high and loads the register defaults (type 0, 200, 2000).
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module rotary_encoder_button_decoder_top (
    input  wire  logic                                   aclk,
    input  wire  logic                                   aresetn,
    input  wire  logic                                   cfg_wr_en,
    input  wire  logic [rebd_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire  logic [rebd_pkg::CFG_DATA_W-1:0]        cfg_wr_data,
    input  wire  logic                                   s_valid,
    output       logic                                   s_ready,
    input  wire  logic [1:0]                             s_mode,
    input  wire  logic                                   s_pin_a,
    input  wire  logic                                   s_pin_b,
    input  wire  logic                                   s_pin_button,
    output       logic                                   m_valid,
    input  wire  logic                                   m_ready,
    output       logic signed [rebd_pkg::TURN_W-1:0]     m_rotation_count,
    output       logic [2:0]                             m_button_event
);
    import rebd_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [1:0]             enc_type_reg;
    logic [CFG_DATA_W-1:0]  debounce_reg;
    logic [CFG_DATA_W-1:0]  longpress_reg;

    logic                   prev_a_reg, prev_button_reg;
    logic [TURN_W-1:0]      turn_reg, turn_next, turn_res;
    logic                   press_active_reg, press_active_next;
    logic [COUNT_WIDTH-1:0] press_ticks_reg, press_ticks_next;
    btn_event_t             event_reg, event_next, event_res;

    logic                   out_valid_reg, out_valid_next;
    logic [TURN_W-1:0]      out_turn_reg, out_turn_next;
    btn_event_t             out_event_reg, out_event_next;
    logic                   skid_valid_reg, skid_valid_next;
    logic [TURN_W-1:0]      skid_turn_reg, skid_turn_next;
    btn_event_t             skid_event_reg, skid_event_next;

    logic                   in_xfer, out_xfer;
    op_mode_t               mode;
    logic                   down;
    logic [CMP_W-1:0]       ticks_ext, deb_ext, long_ext;
    logic [COUNT_WIDTH-1:0] ticks_inc;

    assign in_xfer  = s_valid && s_ready;
    assign out_xfer = out_valid_reg && m_ready;
    assign mode     = op_mode_t'(s_mode);

    assign ticks_ext = CMP_W'(press_ticks_reg);
    assign deb_ext   = CMP_W'(debounce_reg);
    assign long_ext  = CMP_W'(longpress_reg);
    assign ticks_inc = (press_ticks_reg == CNT_MAX) ? press_ticks_reg
                                                    : press_ticks_reg + 1'b1;

    always_comb begin
        turn_res          = turn_reg;
        event_res         = event_reg;
        press_active_next = press_active_reg;
        press_ticks_next  = press_ticks_reg;
        down              = 1'b0;

        if (mode == MODE_TICK) begin
            if (!enc_type_reg[1]) begin
                down = (s_pin_a == s_pin_b) ^ enc_type_reg[0];
                if (prev_a_reg != s_pin_a) begin
                    turn_res = down ? turn_reg - 1'b1 : turn_reg + 1'b1;
                end
            end else begin
                down = s_pin_b ^ enc_type_reg[0];
                if (!prev_a_reg && s_pin_a) begin
                    turn_res = down ? turn_reg - 1'b1 : turn_reg + 1'b1;
                end
            end

            priority if (prev_button_reg && !s_pin_button) begin
                press_active_next = 1'b1;
                press_ticks_next  = '0;
            end else if (press_active_reg && s_pin_button) begin
                press_active_next = 1'b0;
                priority if (ticks_ext < deb_ext) begin
                    event_res = EV_NONE;
                end else if (ticks_ext < long_ext && event_reg == EV_NONE) begin
                    event_res = EV_CLICK;
                end else if (event_reg == EV_HOLD) begin
                    event_res = EV_HOLD_DONE;
                end else begin
                    event_res = event_reg;
                end
            end else if (press_active_reg) begin
                priority if (ticks_ext < deb_ext) begin
                    press_ticks_next = ticks_inc;
                    turn_res         = '0;
                end else if (ticks_ext < long_ext) begin
                    if (turn_res != '0) begin
                        event_res = EV_HOLD;
                    end
                    if (event_res == EV_NONE) begin
                        press_ticks_next = ticks_inc;
                    end
                end else if (ticks_ext == long_ext) begin
                    press_ticks_next = ticks_inc;
                    event_res        = EV_LONG;
                end else begin
                    press_ticks_next = press_ticks_reg;
                end
            end
        end

        turn_next  = turn_res;
        event_next = event_res;
        unique case (mode)
            MODE_RD_BTN: begin
                if (event_res != EV_HOLD) begin
                    event_next = EV_NONE;
                end
            end
            MODE_RD_TURN: begin
                turn_next = '0;
            end
            default: begin
            end
        endcase
    end

    // output register and skid stage
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_turn_next   = out_turn_reg;
        out_event_next  = out_event_reg;
        skid_valid_next = skid_valid_reg;
        skid_turn_next  = skid_turn_reg;
        skid_event_next = skid_event_reg;

        if (out_xfer) begin
            out_valid_next  = skid_valid_reg;
            out_turn_next   = skid_turn_reg;
            out_event_next  = skid_event_reg;
            skid_valid_next = 1'b0;
        end
        if (in_xfer) begin
            if (out_valid_next) begin
                skid_valid_next = 1'b1;
                skid_turn_next  = turn_res;
                skid_event_next = event_res;
            end else begin
                out_valid_next = 1'b1;
                out_turn_next  = turn_res;
                out_event_next = event_res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enc_type_reg     <= ENC_TYPE_RST;
            debounce_reg     <= DEBOUNCE_RST;
            longpress_reg    <= LONGPRESS_RST;
            prev_a_reg       <= 1'b1;
            prev_button_reg  <= 1'b1;
            turn_reg         <= '0;
            press_active_reg <= 1'b0;
            press_ticks_reg  <= '0;
            event_reg        <= EV_NONE;
            out_valid_reg    <= 1'b0;
            skid_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_ENC_TYPE:  enc_type_reg  <= cfg_wr_data[1:0];
                    REG_DEBOUNCE:  debounce_reg  <= cfg_wr_data;
                    REG_LONGPRESS: longpress_reg <= cfg_wr_data;
                    default: begin
                    end
                endcase
            end
            if (in_xfer) begin
                if (mode == MODE_TICK) begin
                    prev_a_reg      <= s_pin_a;
                    prev_button_reg <= s_pin_button;
                end
                turn_reg         <= turn_next;
                press_active_reg <= press_active_next;
                press_ticks_reg  <= press_ticks_next;
                event_reg        <= event_next;
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_turn_reg   <= out_turn_next;
        out_event_reg  <= out_event_next;
        skid_turn_reg  <= skid_turn_next;
        skid_event_reg <= skid_event_next;
    end

    assign s_ready          = !skid_valid_reg;
    assign m_valid          = out_valid_reg;
    assign m_rotation_count = signed'(out_turn_reg);
    assign m_button_event   = out_event_reg;

    a_skid_implies_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage holds data while output register is empty");

    a_turn_read_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && s_mode == MODE_RD_TURN) |=> (turn_reg == '0))
        else $error("rotation count not cleared after read");

    a_btn_read_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && s_mode == MODE_RD_BTN && event_reg != EV_HOLD)
        |=> (event_reg == EV_NONE))
        else $error("button event not cleared after read");

    a_event_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_button_event <= 3'd4))
        else $error("result carries an undefined button event");

endmodule : rotary_encoder_button_decoder_top
`default_nettype wire

// ===== test/rebd_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the rotary encoder and push button decoder.
// Watches the register, input and result ports, predicts every result and compares it;
// depends on rebd_pkg.
module rebd_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [rebd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rebd_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    input  logic                               s_valid,
    input  logic                               s_ready,
    input  logic [1:0]                         s_mode,
    input  logic                               s_pin_a,
    input  logic                               s_pin_b,
    input  logic                               s_pin_button,
    input  logic                               m_valid,
    input  logic                               m_ready,
    input  logic signed [rebd_pkg::TURN_W-1:0] m_rotation_count,
    input  logic [2:0]                         m_button_event,
    output int                                 mismatches,
    output int                                 outstanding,
    output int                                 results_checked
);
    import rebd_pkg::*;

    typedef struct packed {
        logic [TURN_W-1:0] count;
        btn_event_t        evt;
    } readout_t;

    readout_t readout_q[$];

    logic [1:0]             enc_type;
    logic [CFG_DATA_W-1:0]  debounce_lim;
    logic [CFG_DATA_W-1:0]  longpress_lim;
    logic                   last_a;
    logic                   last_btn;
    logic [TURN_W-1:0]      turn_total;
    logic                   pressed;
    logic [COUNT_WIDTH-1:0] press_ticks;
    btn_event_t             held_event;

    initial begin
        mismatches      = 0;
        outstanding     = 0;
        results_checked = 0;
    end

    task automatic report_mismatch(input string what);
        $display("%0t: mismatch: %s", $time, what);
        mismatches++;
    endtask

    task automatic advance_press();
        if (press_ticks != '1) begin
            press_ticks = press_ticks + 1'b1;
        end
    endtask

    task automatic decode_step(input op_mode_t op, input logic a, input logic b,
                               input logic btn, output readout_t r);
        logic down;
        if (op == MODE_TICK) begin
            if (enc_type[1] ? (!last_a && a) : (last_a != a)) begin
                down = (enc_type[1] ? b : (a == b)) ^ enc_type[0];
                turn_total = down ? turn_total - 1'b1 : turn_total + 1'b1;
            end
            if (last_btn && !btn) begin
                pressed     = 1'b1;
                press_ticks = '0;
            end else if (pressed && btn) begin
                pressed = 1'b0;
                if (press_ticks < debounce_lim) begin
                    held_event = EV_NONE;
                end else if (press_ticks < longpress_lim && held_event == EV_NONE) begin
                    held_event = EV_CLICK;
                end else if (held_event == EV_HOLD) begin
                    held_event = EV_HOLD_DONE;
                end
            end else if (pressed) begin
                if (press_ticks < debounce_lim) begin
                    advance_press();
                    turn_total = '0;
                end else if (press_ticks < longpress_lim) begin
                    if (turn_total != '0) begin
                        held_event = EV_HOLD;
                    end
                    if (held_event == EV_NONE) begin
                        advance_press();
                    end
                end else if (press_ticks == longpress_lim) begin
                    advance_press();
                    held_event = EV_LONG;
                end
            end
            last_a   = a;
            last_btn = btn;
        end
        r.count = turn_total;
        r.evt   = held_event;
        if (op == MODE_RD_BTN) begin
            if (held_event != EV_HOLD) begin
                held_event = EV_NONE;
            end
        end else if (op == MODE_RD_TURN) begin
            turn_total = '0;
        end
    endtask

    always @(posedge aclk) begin
        readout_t want;
        readout_t got;
        if (!aresetn) begin
            enc_type      = ENC_TYPE_RST;
            debounce_lim  = DEBOUNCE_RST;
            longpress_lim = LONGPRESS_RST;
            last_a        = 1'b1;
            last_btn      = 1'b1;
            turn_total    = '0;
            pressed       = 1'b0;
            press_ticks   = '0;
            held_event    = EV_NONE;
            readout_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                results_checked++;
                if (readout_q.size() == 0) begin
                    report_mismatch("result transfer with no item outstanding");
                end else begin
                    want = readout_q.pop_front();
                    if (m_rotation_count !== want.count) begin
                        report_mismatch($sformatf("rotation_count %0d, expected %0d",
                                                  m_rotation_count, $signed(want.count)));
                    end
                    if (m_button_event !== want.evt) begin
                        report_mismatch($sformatf("button_event %0d, expected %0d",
                                                  m_button_event, want.evt));
                    end
                end
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_ENC_TYPE: begin
                        enc_type = cfg_wr_data[1:0];
                    end
                    REG_DEBOUNCE: begin
                        debounce_lim = cfg_wr_data;
                    end
                    REG_LONGPRESS: begin
                        longpress_lim = cfg_wr_data;
                    end
                    default: begin
                    end
                endcase
            end
            if (s_valid && s_ready) begin
                decode_step(op_mode_t'(s_mode), s_pin_a, s_pin_b, s_pin_button, got);
                readout_q.push_back(got);
            end
        end
        outstanding = readout_q.size();
    end

endmodule

// ===== test/tb_rotary_encoder_button_decoder_top.sv =====
`timescale 1ns / 1ps
// Testbench top for the rotary encoder and push button decoder.
// Drives knob, button and read transfers under several register settings with random
// idling on both sides; depends on rebd_pkg, rebd_checker and the block itself.
module tb_rotary_encoder_button_decoder_top;
    import rebd_pkg::*;

    logic                        aclk;
    logic                        aresetn;
    logic                        cfg_wr_en;
    logic [CFG_IDX_W-1:0]        cfg_index;
    logic [CFG_DATA_W-1:0]       cfg_wr_data;
    logic                        s_valid;
    logic                        s_ready;
    logic [1:0]                  s_mode;
    logic                        s_pin_a;
    logic                        s_pin_b;
    logic                        s_pin_button;
    logic                        m_valid;
    logic                        m_ready;
    logic signed [TURN_W-1:0]    m_rotation_count;
    logic [2:0]                  m_button_event;

    int         mismatches;
    int         outstanding;
    int         results_checked;
    int         items_sent       = 0;
    int         settings_applied = 0;
    int         cur_deb;
    int         cur_lp;
    logic [1:0] knob_phase;
    logic       btn_level;
    bit         idle_on          = 1'b1;
    bit         hold_off_req     = 1'b0;

    int deb_tab [10] = '{1, 2, 0, 3, 65535, 5, 1, 4, 65534, 2};
    int lp_tab  [10] = '{2, 8, 0, 12, 65535, 3, 65534, 20, 6, 1};

    rotary_encoder_button_decoder_top u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_mode           (s_mode),
        .s_pin_a          (s_pin_a),
        .s_pin_b          (s_pin_b),
        .s_pin_button     (s_pin_button),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_rotation_count (m_rotation_count),
        .m_button_event   (m_button_event)
    );

    rebd_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_mode           (s_mode),
        .s_pin_a          (s_pin_a),
        .s_pin_b          (s_pin_b),
        .s_pin_button     (s_pin_button),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_rotation_count (m_rotation_count),
        .m_button_event   (m_button_event),
        .mismatches       (mismatches),
        .outstanding      (outstanding),
        .results_checked  (results_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int pick_gap();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    endfunction

    function automatic int pick_hold();
        int h;
        case ($urandom_range(0, 3))
            0: h = $urandom_range(0, 6);
            1: h = cur_deb + $urandom_range(0, 2) - 1;
            2: h = cur_lp + $urandom_range(0, 3) - 1;
            default: h = $urandom_range(0, 30);
        endcase
        if (h < 0) begin
            h = 0;
        end
        return (h > 40) ? 40 : h;
    endfunction

    task automatic send_item(input op_mode_t op, input logic a, input logic b,
                             input logic btn);
        int gap;
        @(negedge aclk);
        s_valid      <= 1'b1;
        s_mode       <= op;
        s_pin_a      <= a;
        s_pin_b      <= b;
        s_pin_button <= btn;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = pick_gap();
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    task automatic send_tick();
        send_item(MODE_TICK, knob_phase[1], knob_phase[1] ^ knob_phase[0], btn_level);
    endtask

    task automatic send_read(input op_mode_t op);
        send_item(op, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
    endtask

    task automatic step_knob(input bit cw);
        knob_phase = knob_phase + (cw ? 2'd1 : 2'd3);
        send_tick();
    endtask

    task automatic knob_run(input int n, input bit cw);
        repeat (n) begin
            step_knob(($urandom_range(0, 19) == 0) ? !cw : cw);
        end
    endtask

    task automatic press_cycle(input int hold, input bit twist, input bit peek);
        btn_level = 1'b0;
        send_tick();
        repeat (hold) begin
            if (twist && $urandom_range(0, 2) == 0) begin
                step_knob(1'($urandom_range(0, 1)));
            end else if (peek && $urandom_range(0, 7) == 0) begin
                send_read(MODE_RD_BTN);
            end else begin
                send_tick();
            end
        end
        btn_level = 1'b1;
        send_tick();
    endtask

    task automatic send_noise();
        op_mode_t   op;
        logic [2:0] pins;
        op   = op_mode_t'(2'($urandom_range(0, 3)));
        pins = 3'($urandom_range(0, 7));
        if (op == MODE_TICK) begin
            knob_phase = {pins[2], pins[2] ^ pins[1]};
            btn_level  = pins[0];
        end
        send_item(op, pins[2], pins[1], pins[0]);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= CFG_DATA_W'(val);
    endtask

    task automatic apply_settings(input int enc, input int deb, input int lp);
        write_reg(REG_ENC_TYPE, enc);
        write_reg(REG_DEBOUNCE, deb);
        write_reg(REG_LONGPRESS, lp);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        cur_deb = deb;
        cur_lp  = lp;
        settings_applied++;
    endtask

    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (2) @(negedge aclk);
    endtask

    task automatic run_random(input int n);
        int stop_at;
        int pick;
        stop_at = items_sent + n;
        while (items_sent < stop_at) begin
            pick = $urandom_range(0, 29);
            if (pick <= 8) begin
                knob_run($urandom_range(1, 8), 1'($urandom_range(0, 1)));
            end else if (pick == 9) begin
                knob_run($urandom_range(100, 300), 1'($urandom_range(0, 1)));
            end else if (pick <= 19) begin
                press_cycle(pick_hold(), 1'($urandom_range(0, 1)), 1'b1);
            end else if (pick <= 25) begin
                send_read(($urandom_range(0, 1) == 0) ? MODE_RD_BTN : MODE_RD_TURN);
            end else begin
                repeat ($urandom_range(1, 4)) send_noise();
            end
        end
    endtask

    initial begin : receiver
        int gap;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                m_ready <= 1'b0;
                repeat (300) @(negedge aclk);
                hold_off_req = 1'b0;
                m_ready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                gap = pick_gap();
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = REG_ENC_TYPE;
        cfg_wr_data  = '0;
        s_valid      = 1'b0;
        s_mode       = MODE_TICK;
        s_pin_a      = 1'b1;
        s_pin_b      = 1'b1;
        s_pin_button = 1'b1;
        knob_phase   = 2'd2;
        btn_level    = 1'b1;
        cur_deb      = int'(DEBOUNCE_RST);
        cur_lp       = int'(LONGPRESS_RST);
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        run_random(80);

        settle();
        apply_settings(0, 2, 4);
        send_read(MODE_RD_TURN);
        send_read(MODE_RD_BTN);
        send_read(MODE_NOP);
        btn_level = 1'b0;
        send_tick();
        step_knob(1'b1);
        btn_level = 1'b1;
        send_tick();
        press_cycle(3, 1'b0, 1'b0);
        send_read(MODE_RD_BTN);
        press_cycle(5, 1'b0, 1'b0);
        send_read(MODE_RD_BTN);
        btn_level = 1'b0;
        send_tick();
        send_tick();
        send_tick();
        step_knob(1'b1);
        send_read(MODE_RD_BTN);
        btn_level = 1'b1;
        send_tick();
        send_read(MODE_RD_BTN);
        send_read(MODE_RD_TURN);

        for (int p = 1; p <= 10; p++) begin
            settle();
            apply_settings(p % 4, deb_tab[p - 1], lp_tab[p - 1]);
            if (p == 3) begin
                idle_on      = 1'b0;
                hold_off_req = 1'b1;
                knob_run(24, 1'b1);
                idle_on      = 1'b1;
            end
            run_random(110);
        end

        settle();
        repeat (4) @(posedge aclk);
        $display("Covered %0d input transfers and %0d checked results over %0d register settings.",
                 items_sent, results_checked, settings_applied);
        $display("Included wrapped counts, bounced, short, long and turn-while-held presses,");
        $display("odd register values and a long receiver stall.");
        if (mismatches == 0 && outstanding == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
